// ===== src/etp_pkg.sv =====
// etp_pkg: shared types and constants of the edge transition profiler
// operation codes, table entry layout and the update request and result records
// no dependencies
package etp_pkg;

	localparam int PT_W    = 4;
	localparam int CNT_W   = 32;
	localparam int STAMP_W = 64;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_MARK  = 2'd1,
		OP_READ  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	// one edge of the table as stored in memory
	typedef struct packed {
		logic [CNT_W-1:0]   cnt;
		logic [STAMP_W-1:0] sum;
	} entry_t;

	localparam int ENTRY_W = CNT_W + STAMP_W;

	// control handed from the sequencer to the update unit
	typedef struct packed {
		op_t  op;
		logic edge_ok;
	} upd_req_t;

	// one result beat
	typedef struct packed {
		logic [CNT_W-1:0]   cnt;
		logic [STAMP_W-1:0] sum;
		logic [STAMP_W-1:0] elapsed;
	} res_t;

endpackage

// ===== src/edge_transition_profiler.sv =====
// edge_transition_profiler: top level, sequencer around the edge table ram
// depends on etp_pkg, etp_ram, etp_update
//
// usage
// - input channel (in_valid/in_ready) takes one beat of op, point, from_point,
//   timestamp; ops are start, mark and read, code 3 does nothing
// - output channel (out_valid/out_ready) returns one beat per input beat with
//   edge_count, edge_sum and elapsed, in input order
// - each beat is a ram read-modify-write: the edge entry is read from the
//   table ram in the accept cycle and, for a valid mark, the updated entry
//   written back as the modify state ends; no new beat is taken before then
// - out_valid rises as the modify state ends, which waits while the output
//   register still holds a result that the receiver has not taken
// - after reset a clearing pass writes zero to all POINTS*POINTS table
//   entries, one per cycle; in_ready stays low until the pass is done
// - a finished beat waits in the output register while the next input beat
//   is taken; if the receiver still stalls when that beat is done, the block
//   holds it and takes no new input until the output register frees up
module edge_transition_profiler #(
	parameter int POINTS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     op,
	input  logic [etp_pkg::PT_W-1:0]       point,
	input  logic [etp_pkg::PT_W-1:0]       from_point,
	input  logic [etp_pkg::STAMP_W-1:0]    timestamp,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [etp_pkg::CNT_W-1:0]      edge_count,
	output logic [etp_pkg::STAMP_W-1:0]    edge_sum,
	output logic [etp_pkg::STAMP_W-1:0]    elapsed
);

	localparam int DEPTH = POINTS * POINTS;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RMW
	} state_t;

	state_t                        state_q;
	logic [AW-1:0]                 clr_addr_q;
	logic [etp_pkg::PT_W-1:0]      prev_point_q;
	logic [etp_pkg::STAMP_W-1:0]   prev_stamp_q;
	etp_pkg::upd_req_t             req_q;
	logic [etp_pkg::PT_W-1:0]      point_q;
	logic [etp_pkg::STAMP_W-1:0]   stamp_q;
	logic [AW-1:0]                 addr_q;
	logic                          out_valid_q;
	etp_pkg::res_t                 res_q;

	etp_pkg::op_t                  op_in;
	logic                          accept;
	logic                          pt_ok;
	logic                          from_ok;
	logic                          prev_ok;
	logic [etp_pkg::PT_W-1:0]      sel_from;
	logic [AW-1:0]                 rd_addr;
	logic                          in_edge_ok;
	logic                          out_free;
	logic                          finish;
	etp_pkg::entry_t               rd_entry;
	etp_pkg::entry_t               new_entry;
	logic                          upd_we;
	etp_pkg::res_t                 upd_res;
	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	etp_pkg::entry_t               ram_wdata;

	// input decode and table address of the addressed edge
	assign op_in    = etp_pkg::op_t'(op);
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign pt_ok    = (32'(point) < 32'(POINTS));
	assign from_ok  = (32'(from_point) < 32'(POINTS));
	assign prev_ok  = (32'(prev_point_q) < 32'(POINTS));
	assign sel_from = (op_in == etp_pkg::OP_MARK) ? prev_point_q : from_point;
	assign rd_addr  = AW'(32'(point) * 32'(POINTS) + 32'(sel_from));

	always_comb begin
		in_edge_ok = 1'b0;
		unique case (op_in)
			etp_pkg::OP_MARK: in_edge_ok = pt_ok && prev_ok;
			etp_pkg::OP_READ: in_edge_ok = pt_ok && from_ok;
			default:          in_edge_ok = 1'b0;
		endcase
	end

	// edge table
	etp_ram #(
		.WIDTH (etp_pkg::ENTRY_W),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (rd_entry)
	);

	// modify step
	etp_update u_update (
		.req        (req_q),
		.old_entry  (rd_entry),
		.stamp      (stamp_q),
		.prev_stamp (prev_stamp_q),
		.new_entry  (new_entry),
		.we         (upd_we),
		.res        (upd_res)
	);

	// write back, or zero fill during the clearing pass
	assign out_free  = !out_valid_q || out_ready;
	assign finish    = (state_q == ST_RMW) && out_free;
	assign ram_we    = (state_q == ST_CLEAR) || (finish && upd_we);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_addr_q : addr_q;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : new_entry;

	// sequencer, previous mark state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_addr_q   <= '0;
			prev_point_q <= '0;
			prev_stamp_q <= '0;
			out_valid_q  <= 1'b0;
			req_q        <= '0;
			point_q      <= '0;
			stamp_q      <= '0;
			addr_q       <= '0;
			res_q        <= '0;
		end else begin
			// output beat taken with no new one behind it
			if (out_valid_q && out_ready && !finish) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (32'(clr_addr_q) == 32'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
					clr_addr_q <= clr_addr_q + AW'(1);
				end
				ST_IDLE: begin
					if (accept) begin
						state_q     <= ST_RMW;
						req_q.op    <= op_in;
						req_q.edge_ok <= in_edge_ok;
						point_q     <= point;
						stamp_q     <= timestamp;
						addr_q      <= rd_addr;
					end
				end
				ST_RMW: begin
					if (out_free) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
						res_q       <= upd_res;
						if (req_q.op == etp_pkg::OP_START) begin
							prev_stamp_q <= stamp_q;
							prev_point_q <= '0;
						end else if (req_q.op == etp_pkg::OP_MARK) begin
							prev_stamp_q <= stamp_q;
							if (req_q.edge_ok) begin
								prev_point_q <= point_q;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign edge_count = res_q.cnt;
	assign edge_sum   = res_q.sum;
	assign elapsed    = res_q.elapsed;

`ifndef NO_ASSERTIONS
	// an accepted beat always goes to the modify step next
	a_accept_to_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RMW))
		else $error("accepted beat did not enter modify step");

	// the table is never written while waiting for input
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q != ST_IDLE))
		else $error("table write while idle");

	// a new result only appears right after a modify step
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_RMW))
		else $error("result without modify step");
`endif

endmodule

// ===== src/etp_ram.sv =====
// etp_ram: generic single write port, single read port ram with registered read
// no dependencies
module etp_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/etp_update.sv =====
// etp_update: modify step of the table read-modify-write
// computes elapsed ticks, the new edge entry and the result beat
// depends on etp_pkg
module etp_update (
	input  etp_pkg::upd_req_t            req,
	input  etp_pkg::entry_t              old_entry,
	input  logic [etp_pkg::STAMP_W-1:0]  stamp,
	input  logic [etp_pkg::STAMP_W-1:0]  prev_stamp,
	output etp_pkg::entry_t              new_entry,
	output logic                         we,
	output etp_pkg::res_t                res
);

	logic [etp_pkg::STAMP_W-1:0] diff;

	// wrapping tick difference since the last mark or start
	assign diff = stamp - prev_stamp;

	always_comb begin
		new_entry.cnt = old_entry.cnt + etp_pkg::CNT_W'(1);
		new_entry.sum = old_entry.sum + diff;
		we            = 1'b0;
		res           = '0;
		unique case (req.op)
			etp_pkg::OP_START: begin
				res = '0;
			end
			etp_pkg::OP_MARK: begin
				res.elapsed = diff;
				if (req.edge_ok) begin
					we      = 1'b1;
					res.cnt = new_entry.cnt;
					res.sum = new_entry.sum;
				end
			end
			etp_pkg::OP_READ: begin
				if (req.edge_ok) begin
					res.cnt = old_entry.cnt;
					res.sum = old_entry.sum;
				end
			end
			etp_pkg::OP_NOP: begin
				res = '0;
			end
		endcase
	end

endmodule
